### rtl/alsm_pkg.sv
package alsm_pkg;

  localparam int DEF_CHANNELS    = 2;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [15:0] THRESH_RESET = 16'd163;
  localparam logic [15:0] RMS_MAX      = 16'd32768;

  typedef enum logic [1:0] {
    FN_FRAME   = 2'd0,
    FN_SILENT  = 2'd1,
    FN_IVL_RPT = 2'd2,
    FN_TOT_RPT = 2'd3
  } func_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ADD,
    ST_CLOSE,
    ST_RLOAD,
    ST_DIVGO,
    ST_DIVW,
    ST_SQGO,
    ST_SQW,
    ST_PMGO,
    ST_PMW,
    ST_RFIN
  } state_t;

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  function automatic logic [63:0] sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

### rtl/audio_level_silence_meter_unit.sv
// Channel  | Ports                 | Direction | Handshake
// in       | in_*                  | input     | in_valid / in_stall
// out      | out_*                 | output    | out_valid / out_stall
// cfg      | cfg_silence_threshold | input     | cfg_valid / cfg_ready
//
// Audio frame: a square and an add state per channel, then a close state when it ends a
// packet (one multiplier). Silent packet: a close state. Report: with no frames it goes
// straight to finish; if every frame is silent only the permille divide runs, else the
// shared one-bit-per-cycle divide (64 steps, twice) and square root (32 steps) run.
// in_stall is high while an item is in work; a report waiting on out_stall
// holds only if an earlier report is still unread. Synchronous active-low reset.
module audio_level_silence_meter_unit
  import alsm_pkg::*;
#(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_func,
  input  logic [SAMPLE_BITS-1:0] in_left_sample,
  input  logic [SAMPLE_BITS-1:0] in_right_sample,
  input  logic                   in_last_of_packet,
  input  logic                   in_discontinuity,
  input  logic [15:0]            in_silent_frame_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_report_kind,
  output logic [31:0]            out_packet_count,
  output logic [47:0]            out_frame_count,
  output logic [15:0]            out_rms_level,
  output logic [15:0]            out_peak_level,
  output logic [9:0]             out_silence_permille,
  output logic [31:0]            out_discontinuity_count,
  output logic                   out_heard_sound,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [15:0]            cfg_silence_threshold
);

  state_t state_r, state_nxt;

  logic [15:0] thr_r;
  func_t       func_r;
  logic [SAMPLE_BITS-1:0] left_r, right_r;
  logic        last_r, disc_r;
  logic [15:0] sfc_r;
  logic        ch_r;

  logic [15:0] pkt_peak_r, pkt_frames_r;
  logic [47:0] pkt_sq_r;
  logic [47:0] sq_r;

  logic [31:0] i_pkts_r, t_pkts_r, i_disc_r, t_disc_r;
  logic [47:0] i_fr_r, t_fr_r, i_si_r, t_si_r;
  logic [63:0] i_sq_r, t_sq_r;
  logic [15:0] i_peak_r, t_peak_r;
  logic        sound_r;

  logic        w_kind_r;
  logic [31:0] w_pkts_r, w_disc_r;
  logic [47:0] w_fr_r, w_si_r;
  logic [63:0] w_sq_r, w_q_r;
  logic [15:0] w_peak_r, rms_r;
  logic [9:0]  pm_r;
  logic        w_sound_r;

  logic        out_valid_r;
  logic        out_load;

  unit_req_t   ureq;
  logic [63:0] u_opa, u_opb, u_res;
  logic        u_done;

  logic [SAMPLE_BITS-1:0]   smp, mag;
  logic [31:0]              mag32;
  logic [15:0]              mag_clip;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic                     last_ch;

  logic [47:0] c_frames, c_silent, sel_fr, sel_si, diff;
  logic [49:0] samples;
  logic [57:0] pm_num;
  logic        accept;

  assign accept  = in_valid && !in_stall;
  assign last_ch = (ch_r == 1'(CHANNELS - 1));

  assign smp      = ch_r ? right_r : left_r;
  assign mag      = smp[SAMPLE_BITS-1] ? (~smp + 1'b1) : smp;
  assign mag32    = 32'(mag);
  assign mag_clip = (mag32 > 32'hFFFF) ? 16'hFFFF : mag32[15:0];
  assign prod     = mag * mag;

  always_comb begin
    if (func_r == FN_FRAME) begin
      c_frames = 48'(pkt_frames_r);
      c_silent = (pkt_peak_r > thr_r) ? 48'd0 : 48'(pkt_frames_r);
    end else begin
      c_frames = 48'(sfc_r);
      c_silent = 48'(sfc_r);
    end
  end

  assign sel_fr  = (func_r == FN_IVL_RPT) ? i_fr_r : t_fr_r;
  assign sel_si  = (func_r == FN_IVL_RPT) ? i_si_r : t_si_r;
  assign diff    = w_fr_r - w_si_r;
  assign samples = 50'(diff) * 50'(CHANNELS);
  // silent * 1000 = silent * (1024 - 32 + 8)
  assign pm_num  = {w_si_r, 10'd0} - {5'd0, w_si_r, 5'd0} + {7'd0, w_si_r, 3'd0};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FN_FRAME:   state_nxt = ST_SQ;
            FN_SILENT:  state_nxt = ST_CLOSE;
            FN_IVL_RPT,
            FN_TOT_RPT: state_nxt = ST_RLOAD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQ:    state_nxt = ST_ADD;
      ST_ADD: begin
        if (!last_ch)    state_nxt = ST_SQ;
        else if (last_r) state_nxt = ST_CLOSE;
        else             state_nxt = ST_IDLE;
      end
      ST_CLOSE: state_nxt = ST_IDLE;
      ST_RLOAD: begin
        if (w_fr_r > w_si_r)     state_nxt = ST_DIVGO;
        else if (w_fr_r != '0)   state_nxt = ST_PMGO;
        else                     state_nxt = ST_RFIN;
      end
      ST_DIVGO: state_nxt = ST_DIVW;
      ST_DIVW:  if (u_done) state_nxt = ST_SQGO;
      ST_SQGO:  state_nxt = ST_SQW;
      ST_SQW:   if (u_done) state_nxt = ST_PMGO;
      ST_PMGO:  state_nxt = ST_PMW;
      ST_PMW:   if (u_done) state_nxt = ST_RFIN;
      ST_RFIN:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ureq.start = 1'b0;
    ureq.op    = OP_DIV;
    u_opa      = '0;
    u_opb      = '0;
    unique case (state_r)
      ST_DIVGO: begin
        ureq.start = 1'b1;
        u_opa      = w_sq_r;
        u_opb      = 64'(samples);
      end
      ST_SQGO: begin
        ureq.start = 1'b1;
        ureq.op    = OP_SQRT;
        u_opa      = w_q_r;
      end
      ST_PMGO: begin
        ureq.start = 1'b1;
        u_opa      = 64'(pm_num);
        u_opb      = 64'(w_fr_r);
      end
      default: ;
    endcase
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = (state_r == ST_IDLE);
    out_load  = (state_r == ST_RFIN) && (!out_valid_r || !out_stall);
  end

  alsm_shared_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ureq),
    .opa    (u_opa),
    .opb    (u_opb),
    .result (u_res),
    .done   (u_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= THRESH_RESET;
      out_valid_r  <= 1'b0;
      pkt_peak_r   <= '0;
      pkt_frames_r <= '0;
      pkt_sq_r     <= '0;
      i_pkts_r <= '0; i_disc_r <= '0; i_fr_r <= '0; i_si_r <= '0;
      i_sq_r   <= '0; i_peak_r <= '0;
      t_pkts_r <= '0; t_disc_r <= '0; t_fr_r <= '0; t_si_r <= '0;
      t_sq_r   <= '0; t_peak_r <= '0;
      sound_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) thr_r <= cfg_silence_threshold;
      if (out_load)                     out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_SQ: begin
          if (mag_clip > pkt_peak_r) pkt_peak_r <= mag_clip;
        end
        ST_ADD: begin
          pkt_sq_r <= sat48(pkt_sq_r, sq_r);
          if (last_ch) pkt_frames_r <= sat16(pkt_frames_r, 16'd1);
        end
        ST_CLOSE: begin
          i_pkts_r <= sat32(i_pkts_r, 32'd1);
          t_pkts_r <= sat32(t_pkts_r, 32'd1);
          i_fr_r   <= sat48(i_fr_r, c_frames);
          t_fr_r   <= sat48(t_fr_r, c_frames);
          i_si_r   <= sat48(i_si_r, c_silent);
          t_si_r   <= sat48(t_si_r, c_silent);
          if (disc_r) begin
            i_disc_r <= sat32(i_disc_r, 32'd1);
            t_disc_r <= sat32(t_disc_r, 32'd1);
          end
          if (func_r == FN_FRAME) begin
            i_sq_r <= sat64(i_sq_r, 64'(pkt_sq_r));
            t_sq_r <= sat64(t_sq_r, 64'(pkt_sq_r));
            if (pkt_peak_r > i_peak_r) i_peak_r <= pkt_peak_r;
            if (pkt_peak_r > t_peak_r) t_peak_r <= pkt_peak_r;
            if (pkt_peak_r > thr_r)    sound_r  <= 1'b1;
            pkt_peak_r   <= '0;
            pkt_frames_r <= '0;
            pkt_sq_r     <= '0;
          end
        end
        ST_RLOAD: begin
          if (func_r == FN_IVL_RPT) begin
            i_pkts_r <= '0; i_disc_r <= '0; i_fr_r <= '0; i_si_r <= '0;
            i_sq_r   <= '0; i_peak_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func_t'(in_func);
      left_r  <= in_left_sample;
      right_r <= in_right_sample;
      last_r  <= in_last_of_packet;
      disc_r  <= in_discontinuity;
      sfc_r   <= in_silent_frame_count;
      ch_r    <= 1'b0;
      // working copy of the counter set for a report
      w_kind_r  <= (func_t'(in_func) == FN_TOT_RPT);
      w_pkts_r  <= (func_t'(in_func) == FN_IVL_RPT) ? i_pkts_r : t_pkts_r;
      w_disc_r  <= (func_t'(in_func) == FN_IVL_RPT) ? i_disc_r : t_disc_r;
      w_sq_r    <= (func_t'(in_func) == FN_IVL_RPT) ? i_sq_r : t_sq_r;
      w_peak_r  <= (func_t'(in_func) == FN_IVL_RPT) ? i_peak_r : t_peak_r;
      w_fr_r    <= (func_t'(in_func) == FN_IVL_RPT) ? i_fr_r : t_fr_r;
      w_si_r    <= (func_t'(in_func) == FN_IVL_RPT) ? i_si_r : t_si_r;
      w_sound_r <= sound_r;
      rms_r     <= '0;
      pm_r      <= '0;
    end
    if (state_r == ST_SQ)                sq_r <= 48'(prod);
    if (state_r == ST_ADD && !last_ch)   ch_r <= 1'b1;
    // silent above frames reads as all silent
    if (state_r == ST_RLOAD && sel_si > sel_fr) w_si_r <= w_fr_r;
    if (state_r == ST_DIVW && u_done)    w_q_r <= u_res;
    if (state_r == ST_SQW && u_done) begin
      rms_r <= (u_res > 64'(RMS_MAX)) ? RMS_MAX : u_res[15:0];
    end
    if (state_r == ST_PMW && u_done)     pm_r <= u_res[9:0];
    if (out_load) begin
      out_report_kind         <= w_kind_r;
      out_packet_count        <= w_pkts_r;
      out_frame_count         <= w_fr_r;
      out_rms_level           <= rms_r;
      out_peak_level          <= w_peak_r;
      out_silence_permille    <= pm_r;
      out_discontinuity_count <= w_disc_r;
      out_heard_sound         <= w_sound_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/alsm_shared_unit.sv
module alsm_shared_unit
  import alsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  unit_req_t   req,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic [63:0] result,
  output logic        done
);

  logic        busy_r;
  logic        done_r;
  unit_op_t    op_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;   // quotient / radicand remainder
  logic [64:0] rem_r;   // remainder / root
  logic [63:0] one_r;
  logic [63:0] b_r;

  logic [64:0] trial;
  logic [64:0] root_try;

  assign trial    = {rem_r[63:0], acc_r[63]};
  assign root_try = {1'b0, rem_r[63:0]} + {1'b0, one_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 6'd0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= opa;
      b_r   <= opb;
      rem_r <= '0;
      one_r <= 64'h4000_0000_0000_0000;
      cnt_r <= (req.op == OP_DIV) ? 6'd63 : 6'd31;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (op_r == OP_DIV) begin
        if (trial >= {1'b0, b_r}) begin
          rem_r <= trial - {1'b0, b_r};
          acc_r <= {acc_r[62:0], 1'b1};
        end else begin
          rem_r <= trial;
          acc_r <= {acc_r[62:0], 1'b0};
        end
      end else begin
        if ({1'b0, acc_r} >= root_try) begin
          acc_r <= acc_r - root_try[63:0];
          rem_r <= {1'b0, (rem_r[63:0] >> 1) + one_r};
        end else begin
          rem_r <= {1'b0, rem_r[63:0] >> 1};
        end
        one_r <= one_r >> 2;
      end
    end
  end

  assign result = (op_r == OP_DIV) ? acc_r : rem_r[63:0];
  assign done   = done_r;

endmodule

### rtl/alsm_checker.sv
module alsm_checker
  import alsm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_rms_level,
  input logic [9:0]  out_silence_permille
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("request dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without work cycle");

  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rms_level <= RMS_MAX)
    else $error("rms out of range");

  a_pm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_silence_permille <= 10'd1000)
    else $error("permille out of range");

endmodule

bind audio_level_silence_meter_unit alsm_checker u_alsm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_rms_level        (out_rms_level),
  .out_silence_permille (out_silence_permille)
);
